@@ rtl/fmts_pkg.sv @@
// Shared types, constants and sine table for the FM tone generator.
// Pure package; no dependencies.
package fmts_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_CARRIER_STEP   = 2'd0;
    localparam logic [1:0] REG_MODULATOR_STEP = 2'd1;
    localparam logic [1:0] REG_MOD_INDEX      = 2'd2;
    localparam logic [1:0] REG_AMPLITUDE      = 2'd3;

    localparam logic [15:0] AMPLITUDE_RESET = 16'd32768;

    // round(2^32 / (2 pi)), split for two 16-bit partial products
    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
    localparam logic [15:0] TPR_LO       = TURN_PER_RAD[15:0];
    localparam logic [15:0] TPR_HI       = TURN_PER_RAD[31:16];
    localparam int          D_LSB        = 55 - PHASE_BITS;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [31:0] carrier_step;
        logic [31:0] modulator_step;
        logic [15:0] mod_index;
        logic [15:0] amplitude;
    } t_cfg;

    typedef logic [QUARTER:0][14:0] t_tab;

    // Quarter-wave table from a Taylor series in Q30, evaluated at elaboration.
    function automatic t_tab build_tab();
        t_tab            tab;
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          e;
        for (int k = 0; k <= QUARTER; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / QUARTER;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            e = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
            if (e > 32767) begin
                e = 32767;
            end
            tab[k] = e[14:0];
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // Signed Q15 sine of a phase, no interpolation.
    function automatic logic signed [15:0] sine_q15(logic [PHASE_BITS-1:0] ph);
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [SINE_TABLE_BITS-3:0] off;
        logic [SINE_TABLE_BITS-2:0] pos;
        logic [14:0]                mag;
        idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
        off = idx[SINE_TABLE_BITS-3:0];
        if (idx[SINE_TABLE_BITS-2]) begin
            pos = (SINE_TABLE_BITS - 1)'(QUARTER) - {1'b0, off};
        end else begin
            pos = {1'b0, off};
        end
        mag = SINE_TAB[pos];
        if (idx[SINE_TABLE_BITS-1]) begin
            return -$signed({1'b0, mag});
        end else begin
            return $signed({1'b0, mag});
        end
    endfunction

endpackage

@@ rtl/fmts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fmts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fmts_regs.sv @@
// APB configuration registers of the FM tone generator.
// Depends on fmts_pkg.
module fmts_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmts_pkg::PADDR_W-1:0]  paddr,
    input  logic [fmts_pkg::PDATA_W-1:0]  pwdata,
    output logic [fmts_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output fmts_pkg::t_cfg                o_cfg
);

    fmts_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_step   <= '0;
            r_cfg.modulator_step <= '0;
            r_cfg.mod_index      <= '0;
            r_cfg.amplitude      <= fmts_pkg::AMPLITUDE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                fmts_pkg::REG_CARRIER_STEP:   r_cfg.carrier_step   <= pwdata;
                fmts_pkg::REG_MODULATOR_STEP: r_cfg.modulator_step <= pwdata;
                fmts_pkg::REG_MOD_INDEX:      r_cfg.mod_index      <= pwdata[15:0];
                fmts_pkg::REG_AMPLITUDE:      r_cfg.amplitude      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fmts_pkg::REG_CARRIER_STEP:   prdata = r_cfg.carrier_step;
            fmts_pkg::REG_MODULATOR_STEP: prdata = r_cfg.modulator_step;
            fmts_pkg::REG_MOD_INDEX:      prdata = {16'd0, r_cfg.mod_index};
            fmts_pkg::REG_AMPLITUDE:      prdata = {16'd0, r_cfg.amplitude};
            default:                      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/fmts_core.sv @@
// Sample sequencer: phase RAM read-modify-write, sine lookups, shared multiplier.
// Depends on fmts_pkg and fmts_ram.
module fmts_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmts_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_sample,
    output logic                 o_clipped
);

    localparam int PB = fmts_pkg::PHASE_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDM  = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_MUL3 = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_SINC = 4'd6;
    localparam logic [3:0] S_MUL4 = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // phase RAM entries
    localparam logic ADDR_CAR = 1'b0;
    localparam logic ADDR_MOD = 1'b1;

    logic [3:0]            r_state, n_state;
    logic                  r_restart;
    logic [1:0]            r_valid;
    logic [PB-1:0]         r_cph;
    logic signed [15:0]    r_sin;
    logic signed [49:0]    r_prod;
    logic signed [32:0]    r_p1;
    logic signed [49:0]    r_lo;
    logic                  r_out_valid;
    logic signed [15:0]    r_sample;
    logic                  r_clipped;

    logic                  ram_we;
    logic                  ram_waddr;
    logic [PB-1:0]         ram_wdata;
    logic                  ram_raddr;
    logic [PB-1:0]         ram_rdata;
    logic [PB-1:0]         phase_now;

    logic signed [32:0]    mul_a;
    logic signed [16:0]    mul_b;
    logic signed [49:0]    mul_p;

    logic [65:0]           dsum;
    logic signed [32:0]    rnd;
    logic signed [17:0]    vfull;
    logic                  sat;

    fmts_ram #(
        .WIDTH (PB),
        .DEPTH (2)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // restart or a never-written entry reads as zero phase
    assign phase_now = (r_restart || !r_valid[ram_waddr]) ? '0 : ram_rdata;

    always_comb begin
        ram_raddr = ADDR_MOD;
        ram_we    = 1'b0;
        ram_waddr = ADDR_MOD;
        ram_wdata = phase_now + i_cfg.modulator_step[PB-1:0];
        unique case (r_state)
            S_RDM: begin
                ram_raddr = ADDR_CAR;
                ram_we    = 1'b1;
            end
            S_MUL1: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_CAR;
                ram_wdata = phase_now + i_cfg.carrier_step[PB-1:0];
            end
            default: ;
        endcase
    end

    // shared 33x17 signed multiplier
    always_comb begin
        mul_a = {{17{r_sin[15]}}, r_sin};
        mul_b = {1'b0, i_cfg.mod_index};
        unique case (r_state)
            S_MUL2: begin
                mul_a = r_prod[32:0];
                mul_b = {1'b0, fmts_pkg::TPR_LO};
            end
            S_MUL3: begin
                mul_a = r_p1;
                mul_b = {1'b0, fmts_pkg::TPR_HI};
            end
            S_MUL4:  mul_b = {1'b0, i_cfg.amplitude};
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // index * sin * K = hi * 2^16 + lo
    assign dsum = {r_prod, 16'd0} + {{16{r_lo[49]}}, r_lo};

    // output rounding and saturation
    assign rnd   = r_prod[32:0] + 33'sd16384;
    assign vfull = rnd[32:15];
    assign sat   = (vfull[17:15] != 3'b000) && (vfull[17:15] != 3'b111);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_RDM;
            S_RDM:   n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_SUM;
            S_SUM:   n_state = S_SINC;
            S_SINC:  n_state = S_MUL4;
            S_MUL4:  n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (i_in_valid) r_restart <= i_restart;
            S_RDM:  r_sin <= fmts_pkg::sine_q15(phase_now);
            S_MUL1: begin
                r_prod <= mul_p;
                r_cph  <= phase_now;
            end
            S_MUL2: begin
                r_prod <= mul_p;
                r_p1   <= r_prod[32:0];
            end
            S_MUL3: begin
                r_prod <= mul_p;
                r_lo   <= r_prod;
            end
            S_SUM:  r_cph <= r_cph + dsum[fmts_pkg::D_LSB +: PB];
            S_SINC: r_sin <= fmts_pkg::sine_q15(r_cph);
            S_MUL4: r_prod <= mul_p;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_clipped <= sat;
                    if (!sat) begin
                        r_sample <= vfull[15:0];
                    end else if (vfull[17]) begin
                        r_sample <= 16'sh8000;
                    end else begin
                        r_sample <= 16'sh7fff;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_clipped   = r_clipped;

endmodule

@@ rtl/fm_tone_synthesis.sv @@
// Top level of the two-operator FM tone generator.
// Depends on fmts_pkg, fmts_regs, fmts_core (which holds fmts_ram).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_restart): one item per sample
//   tick. i_restart = 1 zeroes both phase accumulators before the sample.
//   Output channel (o_out_valid / i_out_ready, o_sample, o_clipped): one
//   item per input item, in order. o_sample is signed Q15 scaled by the
//   amplitude register, rounded and saturated; o_clipped flags saturation.
//   The sequencer walks one item through the phase RAM read-modify-write
//   and four passes of the single shared 33x17 multiplier into the output
//   register before taking the next one.
//   A finished item sits in the output register; the next item is accepted
//   and computed meanwhile, and a stalled receiver holds the sequencer only
//   in its last step until the output register frees.
//   Reset (i_rst_n low, synchronous): registers go to their reset values
//   (amplitude unity, all else zero), phases read as zero until written,
//   no output is pending. No clearing pass is needed.
//   Configuration: APB, registers at 0x0 carrier_step, 0x4 modulator_step,
//   0x8 mod_index, 0xC amplitude; pready is always high.
module fm_tone_synthesis (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmts_pkg::PADDR_W-1:0]  paddr,
    input  logic [fmts_pkg::PDATA_W-1:0]  pwdata,
    output logic [fmts_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_sample,
    output logic                          o_clipped
);

    fmts_pkg::t_cfg cfg;

    // register file; settings must only change while idle, the block does not enforce it
    fmts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sample sequencer with phase RAM and shared multiplier
    fmts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample),
        .o_clipped   (o_clipped)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the FM tone generator: valid/ready stimulus, APB setup,
// and a bit-exact sample predictor with its own sine table. Needs fmts_pkg and the RTL.
module testbench;

    localparam int TBL_BITS = fmts_pkg::SINE_TABLE_BITS;
    localparam int PH_BITS  = fmts_pkg::PHASE_BITS;
    localparam int QTR      = 1 << (TBL_BITS - 2);
    // pi/2 in Q30 and turns-per-radian in Q32
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam longint          RAD_TO_TURN_Q32 = 64'sd683565276;
    localparam int              HOLDOFF_CYCLES  = 400;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
    } t_tone_out;

    // DUT pins, the driven inputs all known from time zero
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            psel        = 1'b0;
    logic                            penable     = 1'b0;
    logic                            pwrite      = 1'b0;
    logic [fmts_pkg::PADDR_W-1:0]    paddr       = '0;
    logic [fmts_pkg::PDATA_W-1:0]    pwdata      = '0;
    logic [fmts_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    logic                            i_restart   = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic signed [15:0]              o_sample;
    logic                            o_clipped;

    // predictor state: register shadows and phase accumulators
    logic [31:0] cfg_carrier_step   = '0;
    logic [31:0] cfg_modulator_step = '0;
    logic [15:0] cfg_mod_index      = '0;
    logic [15:0] cfg_amplitude      = fmts_pkg::AMPLITUDE_RESET;
    logic [PH_BITS-1:0] carrier_acc   = '0;
    logic [PH_BITS-1:0] modulator_acc = '0;
    int quarter_sine [0:QTR];

    bit        restart_q[$];      // items waiting for the driver
    t_tone_out tone_expect_q[$];  // predicted samples, oldest first

    bit in_accepted;
    int burst_left = 1;
    int gap_left   = 0;
    bit pressure_phase = 1'b0;
    bit pressure_done  = 1'b0;
    int holdoff_left   = 0;
    int rx_mode        = 0;
    int rx_mode_left   = 0;
    int rx_tick        = 0;

    int errors     = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_clipped  = 0;
    int n_restarts = 0;
    int n_settings = 0;

    fm_tone_synthesis i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample),
        .o_clipped   (o_clipped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Sine table: truncating Taylor series of sin in Q30, scaled to 32767
    // and rounded. Entry k covers k/QTR of a quarter turn.
    // ------------------------------------------------------------------
    function automatic void fill_quarter_sine();
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint          e;
        for (int k = 0; k <= QTR; k++) begin
            x    = (RIGHT_ANGLE_Q30 * longint'(k)) / QTR;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 10; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            e = (acc * 32767 + (longint'(1) << 29)) >>> 30;
            if (e > 32767) begin
                e = 32767;
            end
            quarter_sine[k] = int'(e);
        end
    endfunction

    // Signed Q15 sine from the top table bits of a phase; odd quadrants
    // mirror the index, the upper half turn negates.
    function automatic int sine_at(logic [PH_BITS-1:0] ph);
        logic [TBL_BITS-1:0] idx;
        int                  off;
        int                  mag;
        idx = ph[PH_BITS-1 -: TBL_BITS];
        off = int'(idx[TBL_BITS-3:0]);
        mag = idx[TBL_BITS-2] ? quarter_sine[QTR - off] : quarter_sine[off];
        return idx[TBL_BITS-1] ? -mag : mag;
    endfunction

    // One tick of the generator: optional phase clear, modulated carrier
    // lookup, gain with round-half-up, saturation, then phase advance.
    function automatic t_tone_out predict_tone(bit restart);
        longint             mod_sine;
        longint             swing;
        longint             level;
        logic [PH_BITS-1:0] car_look;
        t_tone_out          r;
        if (restart) begin
            carrier_acc   = '0;
            modulator_acc = '0;
        end
        mod_sine = sine_at(modulator_acc);
        // index (Q8) * sine (Q15) * turns/rad (Q32) -> phase units, floored
        swing    = (longint'(cfg_mod_index) * mod_sine * RAD_TO_TURN_Q32) >>> (55 - PH_BITS);
        car_look = carrier_acc + swing[PH_BITS-1:0];
        level    = (longint'(cfg_amplitude) * sine_at(car_look) + 16384) >>> 15;
        r.clipped = 1'b0;
        if (level > 32767) begin
            level     = 32767;
            r.clipped = 1'b1;
        end else if (level < -32768) begin
            level     = -32768;
            r.clipped = 1'b1;
        end
        r.sample      = level[15:0];
        carrier_acc   = carrier_acc + cfg_carrier_step[PH_BITS-1:0];
        modulator_acc = modulator_acc + cfg_modulator_step[PH_BITS-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks accepted samples against the oldest prediction, then
    // predicts for an item accepted at the same edge (it can't be the one
    // leaving, every item passes the sequencer and output register first).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tone_out want;
        if (!i_rst_n) begin
            in_accepted = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (o_clipped) begin
                    n_clipped++;
                end
                if (tone_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: sample with nothing expected, got %0d clipped %0b",
                             $time, o_sample, o_clipped);
                end else begin
                    want = tone_expect_q.pop_front();
                    if (o_sample !== want.sample) begin
                        errors++;
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, want.sample, o_sample);
                    end
                    if (o_clipped !== want.clipped) begin
                        errors++;
                        $display("%0t: clip flag mismatch, expected %0b, got %0b",
                                 $time, want.clipped, o_clipped);
                    end
                end
            end
            in_accepted = i_in_valid && o_in_ready;
            if (in_accepted) begin
                n_items++;
                if (i_restart) begin
                    n_restarts++;
                end
                tone_expect_q.push_back(predict_tone(i_restart));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of items with random gaps. Valid and payload are
    // assigned once per falling edge and held until accepted.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic nxt_valid;
        logic nxt_restart;
        nxt_valid   = i_in_valid;
        nxt_restart = i_restart;
        if (i_rst_n && (!i_in_valid || in_accepted)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (restart_q.size() != 0) begin
                nxt_valid   = 1'b1;
                nxt_restart = restart_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    // a third of the bursts run back to back
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left--;
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_restart  <= nxt_restart;
    end

    // ------------------------------------------------------------------
    // Receiver: switches between always ready, coin flip, mostly stalled
    // and a fixed 3-of-7 pattern. In the pressure phase it goes deaf for
    // a long stretch so the output register and then the input back up.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic nxt_ready;
        rx_tick++;
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        if (pressure_phase && !pressure_done) begin
            pressure_done = 1'b1;
            holdoff_left  = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            nxt_ready = 1'b0;
        end else begin
            case (rx_mode)
                0: nxt_ready = 1'b1;
                1: nxt_ready = 1'($urandom_range(0, 1));
                2: nxt_ready = ($urandom_range(0, 3) == 0);
                default: nxt_ready = ((rx_tick % 7) < 3);
            endcase
        end
        i_out_ready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // APB helpers. pready is tied high, the loop only guards the protocol.
    // ------------------------------------------------------------------
    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // 16-bit registers are compared on their own width only
    task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (idx == fmts_pkg::REG_MOD_INDEX || idx == fmts_pkg::REG_AMPLITUDE) ?
               32'h0000_ffff : 32'hffff_ffff;
        apb_xfer(1'b0, idx, 32'h0, rd);
        if ((rd & mask) !== (want & mask)) begin
            errors++;
            $display("%0t: register %0d readback, expected %h, got %h",
                     $time, idx, want & mask, rd & mask);
        end
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        case (idx)
            fmts_pkg::REG_CARRIER_STEP:   cfg_carrier_step   = value;
            fmts_pkg::REG_MODULATOR_STEP: cfg_modulator_step = value;
            fmts_pkg::REG_MOD_INDEX:      cfg_mod_index      = value[15:0];
            default:                      cfg_amplitude      = value[15:0];
        endcase
        read_check(idx, value);
    endtask

    // 16-bit registers get junk in the upper half, which must be dropped
    task automatic apply_setting(input logic [31:0] car, input logic [31:0] modl,
                                 input logic [15:0] index, input logic [15:0] gain);
        set_reg(fmts_pkg::REG_CARRIER_STEP, car);
        set_reg(fmts_pkg::REG_MODULATOR_STEP, modl);
        set_reg(fmts_pkg::REG_MOD_INDEX, {16'($urandom()), index});
        set_reg(fmts_pkg::REG_AMPLITUDE, {16'($urandom()), gain});
        n_settings++;
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3, 4:    return $urandom_range(0, 32'h0010_0000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_index();
        case ($urandom_range(0, 4))
            0:       return 16'h0;
            1:       return 16'hffff;
            2, 3:    return 16'($urandom_range(0, 1024));
            default: return 16'($urandom());
        endcase
    endfunction

    // gains above unity make clipping common
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0;
            1:       return 16'hffff;
            2:       return fmts_pkg::AMPLITUDE_RESET;
            3, 4:    return 16'($urandom_range(32768, 65535));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_items(input int count, input int restart_pct);
        for (int i = 0; i < count; i++) begin
            restart_q.push_back($urandom_range(0, 99) < restart_pct);
        end
    endtask

    // idle: nothing queued, nothing offered, nothing outstanding, then the
    // pipeline latency plus margin so no late sample can slip past
    task automatic wait_idle();
        @(posedge i_clk);
        while (restart_q.size() != 0 || i_in_valid || tone_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        fill_quarter_sine();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of all four registers
        read_check(fmts_pkg::REG_CARRIER_STEP, 32'h0);
        read_check(fmts_pkg::REG_MODULATOR_STEP, 32'h0);
        read_check(fmts_pkg::REG_MOD_INDEX, 32'h0);
        read_check(fmts_pkg::REG_AMPLITUDE, 32'(fmts_pkg::AMPLITUDE_RESET));

        // reset settings: silent output, with and without restart
        restart_q.push_back(1'b1);
        restart_q.push_back(1'b0);
        restart_q.push_back(1'b0);
        wait_idle();

        // quarter-turn carrier at full gain: hits both saturation limits
        apply_setting(32'h4000_0000, 32'h0, 16'h0, 16'hffff);
        restart_q.push_back(1'b1);
        for (int i = 0; i < 7; i++) begin
            restart_q.push_back(1'b0);
        end
        wait_idle();

        // largest index, wrapping carrier step, mid-stream restart
        apply_setting(32'hffff_ffff, 32'h4000_0000, 16'hffff, fmts_pkg::AMPLITUDE_RESET);
        for (int i = 0; i < 8; i++) begin
            restart_q.push_back(i == 4);
        end
        wait_idle();

        // random settings, extremes first; one phase carries the long stall
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0) begin
                apply_setting(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
            end else if (ph == 1) begin
                apply_setting(32'h0, 32'h0, 16'h0, 16'h0);
            end else begin
                apply_setting(pick_step(), pick_step(), pick_index(), pick_gain());
            end
            if (ph == 6) begin
                pressure_phase = 1'b1;
            end
            queue_items(115, (ph % 4 == 3) ? 50 : 3);
            wait_idle();
            pressure_phase = 1'b0;
        end

        $display("Covered %0d items (%0d with restart) and %0d samples, %0d saturated,",
                 n_items, n_restarts, n_results, n_clipped);
        $display("over %0d register settings including a %0d-cycle receiver stall.",
                 n_settings, HOLDOFF_CYCLES);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4ms;
        $display("Timeout with %0d samples still expected", tone_expect_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
